### hdl/aapc_pkg.sv
package aapc_pkg;

  // Field widths
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 4;
  localparam int DIR_W      = 16;
  localparam int LEN_W      = 15;
  localparam int THICK_W    = 6;
  localparam int FLOW_W     = 2;
  localparam int OP_W       = 2;
  localparam int STEP_W     = 12;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Projection datapath
  localparam int DOWN_SHIFT = 14 - FRAC_BITS;
  localparam int HALF       = 1 << (DOWN_SHIFT - 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = DIFF_W + DIR_W;
  localparam int T_W        = PROD_W + 2 - DOWN_SHIFT;
  localparam int CMP_W      = ((T_W > LEN_W + 1) ? T_W : LEN_W + 1) + 1;
  localparam int X_W        = CMP_W + 5;

  // Arrow geometry, in 2^-FRAC_BITS pixel
  localparam int ONE_PX      = 1 << FRAC_BITS;
  localparam int HEAD_LEN_PX = 14;
  localparam int HEAD_HALF   = 9;
  localparam int HEAD_LEN    = HEAD_LEN_PX * ONE_PX;
  localparam int BAND_LEN    = 10 * ONE_PX;
  localparam int PERIOD      = 26 * ONE_PX;
  localparam int PH_W        = $clog2(PERIOD);

  // Band position modulo PERIOD by reciprocal multiply
  localparam int U_W      = LEN_W + 1;
  localparam int RECIP_SH = U_W + PH_W;
  localparam longint RECIP = ((longint'(1) << RECIP_SH) + PERIOD - 1) / PERIOD;
  localparam int Q_W      = U_W - PH_W + 1;
  localparam int QP_W     = RECIP_SH + Q_W;

  // Phase step modulo PERIOD
  localparam int STEP_SH = STEP_W + PH_W;
  localparam longint STEP_RECIP = ((longint'(1) << STEP_SH) + PERIOD - 1) / PERIOD;
  localparam int SQ_W    = (STEP_W >= PH_W) ? STEP_W - PH_W + 1 : 1;
  localparam int SP_W    = STEP_SH + SQ_W;

  // Operations
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;

  // Flow modes
  localparam logic [FLOW_W-1:0] FLOW_OFF      = 2'd0;
  localparam logic [FLOW_W-1:0] FLOW_FORWARD  = 2'd1;
  localparam logic [FLOW_W-1:0] FLOW_BACKWARD = 2'd2;

  // Pixel classes
  localparam logic [CLASS_W-1:0] PC_BACKGROUND = 2'd0;
  localparam logic [CLASS_W-1:0] PC_SHAFT      = 2'd1;
  localparam logic [CLASS_W-1:0] PC_HIGHLIGHT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MODE  = 3'd6;

  typedef struct packed {
    logic [COORD_BITS-1:0]   origin_x;
    logic [COORD_BITS-1:0]   origin_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic [LEN_W-1:0]        len;
    logic [THICK_W-1:0]      thick;
    logic [FLOW_W-1:0]       flow;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_x: '0,
    origin_y: '0,
    dir_x:    16'sd16384,
    dir_y:    '0,
    len:      15'd16,
    thick:    '0,
    flow:     FLOW_OFF
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yx;
    logic signed [PROD_W-1:0] xy;
  } prod_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } phase_cmd_t;

  typedef struct packed {
    logic load_d;
    logic load_e;
  } shade_en_t;

endpackage

### hdl/aapc_project.sv
module aapc_project (
  input  logic                           clk,
  input  logic                           load,
  input  logic [aapc_pkg::COORD_BITS-1:0] pixel_x,
  input  logic [aapc_pkg::COORD_BITS-1:0] pixel_y,
  input  aapc_pkg::cfg_t                 cfg,
  output aapc_pkg::prod_t                prod
);
  import aapc_pkg::*;

  logic signed [DIFF_W-1:0] px;
  logic signed [DIFF_W-1:0] py;
  logic signed [DIR_W-1:0]  dx;
  logic signed [DIR_W-1:0]  dy;
  prod_t                    prod_next;

  always_comb begin
    px = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.origin_x});
    py = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.origin_y});
    dx = $signed(cfg.dir_x);
    dy = $signed(cfg.dir_y);
    prod_next.xx = PROD_W'(px) * PROD_W'(dx);
    prod_next.yy = PROD_W'(py) * PROD_W'(dy);
    prod_next.yx = PROD_W'(py) * PROD_W'(dx);
    prod_next.xy = PROD_W'(px) * PROD_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

### hdl/aapc_phase.sv
module aapc_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [aapc_pkg::STEP_W-1:0]  step,
  input  aapc_pkg::phase_cmd_t         cmd,
  output logic [aapc_pkg::PH_W-1:0]    phase
);
  import aapc_pkg::*;

  logic [SP_W-1:0]   sprod;
  logic [STEP_W-1:0] step_b;
  logic [SQ_W-1:0]   qs_b;
  logic [STEP_W-1:0] step_rem;
  logic [PH_W:0]     sum;
  logic [PH_W-1:0]   phase_next;

  // quotient of step by the period, exact over the step range
  assign sprod = SP_W'(step) * SP_W'(STEP_RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      step_b <= step;
      qs_b   <= sprod[SP_W-1:STEP_SH];
    end
  end

  always_comb begin
    step_rem = step_b - STEP_W'(STEP_W'(qs_b) * STEP_W'(PERIOD));
    sum      = (PH_W+1)'(phase) + (PH_W+1)'(step_rem);
    priority if (cmd.clear) begin
      phase_next = '0;
    end else if (cmd.tick) begin
      phase_next = (sum >= (PH_W+1)'(PERIOD)) ? PH_W'(sum - (PH_W+1)'(PERIOD))
                                               : PH_W'(sum);
    end else begin
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

### hdl/aapc_locate.sv
module aapc_locate (
  input  logic                           clk,
  input  logic                           load,
  input  aapc_pkg::prod_t                prod,
  input  logic [aapc_pkg::PH_W-1:0]      phase,
  output logic signed [aapc_pkg::T_W-1:0] t,
  output logic signed [aapc_pkg::T_W-1:0] s,
  output logic [aapc_pkg::PH_W-1:0]      phase_c
);
  import aapc_pkg::*;

  localparam int W_W = PROD_W + 2;

  logic signed [W_W-1:0] wt;
  logic signed [W_W-1:0] ws;

  // round to nearest, ties up: add half then floor
  always_comb begin
    wt = W_W'($signed(prod.xx)) + W_W'($signed(prod.yy)) + W_W'(HALF);
    ws = W_W'($signed(prod.yx)) - W_W'($signed(prod.xy)) + W_W'(HALF);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t       <= wt[W_W-1:DOWN_SHIFT];
      s       <= ws[W_W-1:DOWN_SHIFT];
      phase_c <= phase;
    end
  end

endmodule

### hdl/aapc_shade.sv
module aapc_shade (
  input  logic                           clk,
  input  aapc_pkg::shade_en_t            en,
  input  logic signed [aapc_pkg::T_W-1:0] t,
  input  logic signed [aapc_pkg::T_W-1:0] s,
  input  logic [aapc_pkg::PH_W-1:0]      phase_c,
  input  aapc_pkg::cfg_t                 cfg,
  output logic [aapc_pkg::CLASS_W-1:0]   pixel_class_e
);
  import aapc_pkg::*;

  logic                    active;
  logic                    fwd;
  logic                    bwd;
  logic [LEN_W-1:0]        len_c;
  logic signed [X_W-1:0]   ts;
  logic signed [X_W-1:0]   sx;
  logic signed [X_W-1:0]   ax;
  logic signed [X_W-1:0]   lx;
  logic signed [X_W-1:0]   head_x;
  logic signed [X_W-1:0]   lo;
  logic signed [X_W-1:0]   hi;
  logic signed [X_W-1:0]   thick_lim;
  logic signed [X_W-1:0]   ax14;
  logic signed [X_W-1:0]   rem9_f;
  logic signed [X_W-1:0]   rem9_b;
  logic                    on_shaft;
  logic                    on_head;
  logic [LEN_W-1:0]        ft;
  logic [U_W-1:0]          u;
  logic [CLASS_W-1:0]      base;

  logic [U_W-1:0]          u_d;
  logic                    banded_d;
  logic [CLASS_W-1:0]      base_d;
  logic [QP_W-1:0]         qprod;

  logic [U_W-1:0]          u_e;
  logic [Q_W-1:0]          q_e;
  logic                    banded_e;
  logic [CLASS_W-1:0]      base_e;
  logic [U_W-1:0]          r;

  always_comb begin
    fwd    = (cfg.flow == FLOW_FORWARD);
    bwd    = (cfg.flow == FLOW_BACKWARD);
    active = fwd || bwd;
    len_c  = (cfg.len < LEN_W'(ONE_PX)) ? LEN_W'(ONE_PX) : cfg.len;

    ts        = X_W'(t);
    sx        = X_W'(s);
    ax        = sx[X_W-1] ? -sx : sx;
    lx        = X_W'(len_c);
    head_x    = X_W'(HEAD_LEN);
    lo        = bwd ? head_x : '0;
    hi        = fwd ? lx - head_x : lx;
    thick_lim = X_W'(cfg.thick) <<< FRAC_BITS;

    on_shaft = (ts >= lo) && (ts <= hi) && ((ax <<< 1) <= thick_lim);

    // head triangle narrows linearly to the tip
    ax14   = X_W'(HEAD_LEN_PX) * ax;
    rem9_f = X_W'(HEAD_HALF) * (lx - ts);
    rem9_b = X_W'(HEAD_HALF) * ts;
    on_head = (fwd && (ts >= lx - head_x) && (ts <= lx) && (ax14 <= rem9_f)) ||
              (bwd && (ts >= '0) && (ts <= head_x) && (ax14 <= rem9_b));

    // distance along the flow; only meaningful on the shaft
    ft = fwd ? t[LEN_W-1:0] : len_c - t[LEN_W-1:0];
    u  = U_W'(ft) + U_W'(PERIOD) - U_W'(phase_c);

    priority if (on_head) begin
      base = PC_HIGHLIGHT;
    end else if (on_shaft) begin
      base = PC_SHAFT;
    end else begin
      base = PC_BACKGROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_d) begin
      u_d      <= u;
      banded_d <= !on_head && on_shaft && active;
      base_d   <= base;
    end
  end

  assign qprod = QP_W'(u_d) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.load_e) begin
      u_e      <= u_d;
      q_e      <= qprod[QP_W-1:RECIP_SH];
      banded_e <= banded_d;
      base_e   <= base_d;
    end
  end

  always_comb begin
    r = u_e - U_W'(U_W'(q_e) * U_W'(PERIOD));
    pixel_class_e = (banded_e && (r < U_W'(BAND_LEN))) ? PC_HIGHLIGHT : base_e;
  end

endmodule

### hdl/animated_arrow_pixel_classifier.sv
// Pipeline: a classify request passes registers A, B, C, D, E and O before its
//   pixel_class appears; tick, restart and unused operations give no result.
// Throughput: one request per cycle; stages hold only while the result is stalled.
// Reset (rst, synchronous, active high) empties the pipeline, clears the chevron
//   phase and returns every configuration register to its reset value.
module animated_arrow_pixel_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [aapc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aapc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [aapc_pkg::OP_W-1:0]        operation,
  input  logic [aapc_pkg::COORD_BITS-1:0]  pixel_x,
  input  logic [aapc_pkg::COORD_BITS-1:0]  pixel_y,
  input  logic [aapc_pkg::STEP_W-1:0]      phase_step,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [aapc_pkg::CLASS_W-1:0]     pixel_class
);
  import aapc_pkg::*;

  // Pipeline:
  //   A  request register
  //   B  four axis/normal products; step quotient for the phase
  //   C  rounded t and s, phase snapshot (ticks and restarts retire at B)
  //   D  head/shaft tests, band position offset
  //   E  quotient of band position by the chevron period
  //   O  result register

  cfg_t                cfg;
  logic                active;

  logic                v_a, v_b, v_c, v_d, v_e;
  logic [OP_W-1:0]     op_a, op_b;
  logic [COORD_BITS-1:0] px_a, py_a;
  logic [STEP_W-1:0]   step_a;

  logic rdy_o, rdy_e, rdy_d, rdy_c, rdy_b, rdy_a;
  logic move_e, move_d, move_c, move_b, adv_b, adv_a, accept;

  prod_t               prod;
  phase_cmd_t          phase_cmd;
  logic [PH_W-1:0]     phase;
  logic signed [T_W-1:0] t_c, s_c;
  logic [PH_W-1:0]     phase_c;
  shade_en_t           shade_en;
  logic [CLASS_W-1:0]  pixel_class_e;

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  cfg.origin_x <= cfg_data[COORD_BITS-1:0];
        CFG_ORIGIN_Y:  cfg.origin_y <= cfg_data[COORD_BITS-1:0];
        CFG_DIR_X:     cfg.dir_x    <= $signed(cfg_data[DIR_W-1:0]);
        CFG_DIR_Y:     cfg.dir_y    <= $signed(cfg_data[DIR_W-1:0]);
        CFG_LENGTH:    cfg.len      <= cfg_data[LEN_W-1:0];
        CFG_THICKNESS: cfg.thick    <= cfg_data[THICK_W-1:0];
        CFG_FLOW_MODE: cfg.flow     <= cfg_data[FLOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign active = (cfg.flow == FLOW_FORWARD) || (cfg.flow == FLOW_BACKWARD);

  // Backpressure: each stage moves when the next one is empty or moving.
  // Only classify requests travel past B, so ticks never wait on the output.
  always_comb begin
    rdy_o  = !result_valid || !result_stall;
    move_e = v_e && rdy_o;
    rdy_e  = !v_e || rdy_o;
    move_d = v_d && rdy_e;
    rdy_d  = !v_d || rdy_e;
    move_c = v_c && rdy_d;
    rdy_c  = !v_c || rdy_d;
    adv_b  = v_b && ((op_b != OP_CLASSIFY) || rdy_c);
    move_b = adv_b && (op_b == OP_CLASSIFY);
    rdy_b  = !v_b || adv_b;
    adv_a  = v_a && rdy_b;
    rdy_a  = !v_a || adv_a;
    accept = req_valid && rdy_a;
  end

  assign req_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a          <= 1'b0;
      v_b          <= 1'b0;
      v_c          <= 1'b0;
      v_d          <= 1'b0;
      v_e          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v_a          <= accept || (v_a && !adv_a);
      v_b          <= adv_a  || (v_b && !adv_b);
      v_c          <= move_b || (v_c && !move_c);
      v_d          <= move_c || (v_d && !move_d);
      v_e          <= move_d || (v_e && !move_e);
      result_valid <= move_e || (result_valid && result_stall);
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_a   <= operation;
      px_a   <= pixel_x;
      py_a   <= pixel_y;
      step_a <= phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      op_b <= op_a;
    end
  end

  aapc_project u_project (
    .clk     (clk),
    .load    (adv_a),
    .pixel_x (px_a),
    .pixel_y (py_a),
    .cfg     (cfg),
    .prod    (prod)
  );

  // Phase changes as a tick or restart leaves B; a classify request in B
  // therefore sees every earlier tick and none of the later ones.
  always_comb begin
    phase_cmd.tick  = adv_b && (op_b == OP_TICK) && active;
    phase_cmd.clear = adv_b && (op_b == OP_RESTART);
  end

  aapc_phase u_phase (
    .clk   (clk),
    .rst   (rst),
    .load  (adv_a),
    .step  (step_a),
    .cmd   (phase_cmd),
    .phase (phase)
  );

  aapc_locate u_locate (
    .clk     (clk),
    .load    (move_b),
    .prod    (prod),
    .phase   (phase),
    .t       (t_c),
    .s       (s_c),
    .phase_c (phase_c)
  );

  always_comb begin
    shade_en.load_d = move_c;
    shade_en.load_e = move_d;
  end

  aapc_shade u_shade (
    .clk           (clk),
    .en            (shade_en),
    .t             (t_c),
    .s             (s_c),
    .phase_c       (phase_c),
    .cfg           (cfg),
    .pixel_class_e (pixel_class_e)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (move_e) begin
      pixel_class <= pixel_class_e;
    end
  end

  // The chevron phase stays inside one period.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < PH_W'(PERIOD))
    else $error("chevron phase out of range");

  // A restart leaves the phase at zero.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    phase_cmd.clear |=> (phase == '0))
    else $error("restart did not clear phase");

  // A tick with the flow off does not move the phase.
  a_tick_off_holds: assert property (@(posedge clk) disable iff (rst)
    (adv_b && (op_b == OP_TICK) && !active) |=> $stable(phase))
    else $error("phase moved on tick while flow is off");

  // Only classify requests reach stage C.
  a_c_is_classify: assert property (@(posedge clk) disable iff (rst)
    (v_b && (op_b != OP_CLASSIFY)) |=> !(v_c && !$past(v_c)))
    else $error("non-classify request entered stage C");

endmodule

### tb/arrow_class_checker.sv
module arrow_class_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [aapc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aapc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic [aapc_pkg::OP_W-1:0]           operation,
  input  logic [aapc_pkg::COORD_BITS-1:0]     pixel_x,
  input  logic [aapc_pkg::COORD_BITS-1:0]     pixel_y,
  input  logic [aapc_pkg::STEP_W-1:0]         phase_step,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic [aapc_pkg::CLASS_W-1:0]        pixel_class,
  output int                                  pending,
  output int                                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import aapc_pkg::*;

  cfg_t                arrow_cfg = CFG_RESET;
  longint              band_phase = 0;
  logic [CLASS_W-1:0]  expected_classes[$];
  int                  waiting = 0;
  int                  failures = 0;

  assign pending    = waiting;
  assign fail_count = failures;

  function automatic longint floor_mod(longint a, longint m);
    longint r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic logic [CLASS_W-1:0] arrow_pixel_class(logic [COORD_BITS-1:0] col,
                                                           logic [COORD_BITS-1:0] row);
    longint dx, dy, ax, ay, t, s, abs_s, len, lo, hi, flow_t;
    bit     active, forward, on_head, on_shaft;
    dx = longint'(col) - longint'(arrow_cfg.origin_x);
    dy = longint'(row) - longint'(arrow_cfg.origin_y);
    ax = longint'($signed(arrow_cfg.dir_x));
    ay = longint'($signed(arrow_cfg.dir_y));
    // Q14 down to sixteenths, round half up (arithmetic shift floors)
    t = (dx * ax + dy * ay + HALF) >>> DOWN_SHIFT;
    s = (dy * ax - dx * ay + HALF) >>> DOWN_SHIFT;
    abs_s = (s < 0) ? -s : s;
    len = longint'(arrow_cfg.len);
    if (len < ONE_PX) len = ONE_PX;
    active  = (arrow_cfg.flow == FLOW_FORWARD) || (arrow_cfg.flow == FLOW_BACKWARD);
    forward = (arrow_cfg.flow == FLOW_FORWARD);
    lo = (active && !forward) ? HEAD_LEN : 0;
    hi = (active && forward) ? len - HEAD_LEN : len;
    on_shaft = (t >= lo) && (t <= hi) && (2 * abs_s <= longint'(arrow_cfg.thick) * ONE_PX);
    on_head = 1'b0;
    if (active) begin
      if (forward && t >= len - HEAD_LEN && t <= len)
        on_head = (14 * abs_s <= HEAD_HALF * (len - t));
      else if (!forward && t >= 0 && t <= HEAD_LEN)
        on_head = (14 * abs_s <= HEAD_HALF * t);
    end
    if (on_head) return PC_HIGHLIGHT;
    if (!on_shaft) return PC_BACKGROUND;
    if (!active) return PC_SHAFT;
    flow_t = forward ? t : len - t;
    return (floor_mod(flow_t - band_phase, PERIOD) < BAND_LEN) ? PC_HIGHLIGHT : PC_SHAFT;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_classes.delete();
      arrow_cfg  = CFG_RESET;
      band_phase = 0;
    end else begin
      // results first: anything returned now belongs to an older request
      if (result_valid && !result_stall) begin
        if (expected_classes.size() == 0) begin
          $error("pixel_class: expected none, actual %0d", pixel_class);
          failures++;
        end else if (expected_classes[0] !== pixel_class) begin
          $error("pixel_class: expected %0d, actual %0d", expected_classes[0], pixel_class);
          failures++;
          void'(expected_classes.pop_front());
        end else begin
          void'(expected_classes.pop_front());
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_ORIGIN_X:  arrow_cfg.origin_x = cfg_data[COORD_BITS-1:0];
          CFG_ORIGIN_Y:  arrow_cfg.origin_y = cfg_data[COORD_BITS-1:0];
          CFG_DIR_X:     arrow_cfg.dir_x    = cfg_data[DIR_W-1:0];
          CFG_DIR_Y:     arrow_cfg.dir_y    = cfg_data[DIR_W-1:0];
          CFG_LENGTH:    arrow_cfg.len      = cfg_data[LEN_W-1:0];
          CFG_THICKNESS: arrow_cfg.thick    = cfg_data[THICK_W-1:0];
          CFG_FLOW_MODE: arrow_cfg.flow     = cfg_data[FLOW_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        case (operation)
          OP_CLASSIFY: expected_classes.push_back(arrow_pixel_class(pixel_x, pixel_y));
          OP_TICK: begin
            if (arrow_cfg.flow == FLOW_FORWARD || arrow_cfg.flow == FLOW_BACKWARD)
              band_phase = floor_mod(band_phase + longint'(phase_step), PERIOD);
          end
          OP_RESTART: band_phase = 0;
          default: ;
        endcase
      end
    end
    waiting <= expected_classes.size();
  end

endmodule

### tb/tb_animated_arrow_pixel_classifier.sv
module tb_animated_arrow_pixel_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import aapc_pkg::*;

  // codes the package leaves unnamed but the fields still allow
  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [FLOW_W-1:0] FLOW_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES   = 10;  // margin for the dut pipeline to retire requests
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 85;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  logic [OP_W-1:0]       operation;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [STEP_W-1:0]     phase_step;
  logic                  result_valid;
  logic                  result_stall;
  logic [CLASS_W-1:0]    pixel_class;

  int pending;
  int fail_count;

  // pacing state: each side alternates calm stretches with random gaps
  int tx_left = 0;
  bit tx_calm = 1'b0;
  int rx_left = 0;
  bit rx_calm = 1'b0;

  // stimulus-side copy of the geometry, only used to aim pixels at the arrow
  int cur_ox, cur_oy, cur_dx, cur_dy, cur_len;

  animated_arrow_pixel_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .phase_step   (phase_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_class  (pixel_class)
  );

  arrow_class_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .phase_step   (phase_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_class  (pixel_class),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wait before the next item: none in calm stretches, else a random draw.
  function automatic int draw_wait(ref int left, ref bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // One request: optional idle gap, then hold valid until it is taken.
  // Valid stays high afterwards so back-to-back requests need no re-raise.
  task automatic send_request(logic [OP_W-1:0] op, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y, logic [STEP_W-1:0] step);
    int gap;
    gap = draw_wait(tx_left, tx_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= op;
    pixel_x    <= x;
    pixel_y    <= y;
    phase_step <= step;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic classify_at(int x, int y);
    send_request(OP_CLASSIFY, x[COORD_BITS-1:0], y[COORD_BITS-1:0], STEP_W'($urandom));
  endtask

  task automatic tick_by(int step);
    send_request(OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom), step[STEP_W-1:0]);
  endtask

  // Stop requesting, let every expected class come back, then give the
  // pipeline time to retire ticks and restarts that leave no result.
  // pending is updated on the clock, so it is read only after the last request is registered.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes every register; only called with the dut drained.
  task automatic program_arrow(int ox, int oy, int dx, int dy, int len, int thick,
                               logic [FLOW_W-1:0] flow);
    cfg_put(CFG_ORIGIN_X,  CFG_DATA_W'(ox[COORD_BITS-1:0]));
    cfg_put(CFG_ORIGIN_Y,  CFG_DATA_W'(oy[COORD_BITS-1:0]));
    cfg_put(CFG_DIR_X,     dx[DIR_W-1:0]);
    cfg_put(CFG_DIR_Y,     dy[DIR_W-1:0]);
    cfg_put(CFG_LENGTH,    CFG_DATA_W'(len[LEN_W-1:0]));
    cfg_put(CFG_THICKNESS, CFG_DATA_W'(thick[THICK_W-1:0]));
    cfg_put(CFG_FLOW_MODE, CFG_DATA_W'(flow));
    cfg_write <= 1'b0;
    cur_ox  = ox;
    cur_oy  = oy;
    cur_dx  = $signed(dx[DIR_W-1:0]);
    cur_dy  = $signed(dy[DIR_W-1:0]);
    cur_len = len;
  endtask

  // Result side: per result draw a stall stretch, then accept one result.
  initial begin : result_pacing
    int gap;
    result_stall <= 1'b0;
    forever begin
      gap = draw_wait(rx_left, rx_calm);
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int  counted, pick, kind, ang, span, tp, sp, xi, yi;
    int  ox, oy, dx, dy, len, thick;
    real rad, ux, uy;
    logic [FLOW_W-1:0] flow;

    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    req_valid  <= 1'b0;
    operation  <= OP_CLASSIFY;
    pixel_x    <= '0;
    pixel_y    <= '0;
    phase_step <= '0;
    cur_ox = 0; cur_oy = 0; cur_dx = 16384; cur_dy = 0; cur_len = 16;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reset geometry: one-pixel arrow along +x, zero thickness, flow off
    classify_at(0, 0);
    classify_at(1, 0);              // exactly at the arrow end
    classify_at(1023, 1023);
    tick_by(300);                   // tick with flow off leaves the phase alone
    classify_at(0, 0);
    drain();

    // 40 px arrow to the right, flow toward the end, 8 px shaft
    program_arrow(100, 100, 16384, 0, 640, 8, FLOW_FORWARD);
    classify_at(100, 100);          // shaft start, inside the first band
    classify_at(110, 100);          // just past the band
    classify_at(100, 104);          // shaft edge (2|s| == thickness)
    classify_at(100, 105);          // just outside
    classify_at(130, 100);          // head
    classify_at(140, 100);          // head tip
    tick_by(4095);                  // step far beyond one period
    classify_at(110, 100);
    send_request(OP_RESTART, 10'd0, 10'd0, 12'd0);
    classify_at(110, 100);
    send_request(OP_UNUSED, 10'h3ff, 10'h3ff, 12'hfff);  // ignored, no result
    classify_at(125, 100);
    drain();

    // leftward from the far corner, short axis raised to one pixel, flow back
    program_arrow(1023, 0, -16384, 0, 0, 63, FLOW_BACKWARD);
    classify_at(1023, 0);
    classify_at(1010, 0);
    tick_by(2000);
    classify_at(1022, 1);
    send_request(OP_RESTART, 10'd0, 10'd0, 12'd0);
    drain();

    // unused flow mode acts as off; non-unit axis vector, longest axis
    program_arrow(0, 1023, -16384, -16384, 32767, 63, FLOW_UNUSED);
    tick_by(100);
    classify_at(0, 1023);
    classify_at(1023, 0);
    classify_at(512, 512);
    drain();

    // --- random phases, each with a fresh geometry ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      ox = $urandom_range(0, 1023);
      oy = $urandom_range(0, 1023);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        ang = $urandom_range(0, 359);
        rad = ang * 3.14159265358979 / 180.0;
        dx = $rtoi(16384.0 * $cos(rad));
        dy = $rtoi(16384.0 * $sin(rad));
      end else if (kind == 7) begin
        // axis-aligned at full scale, either sign
        dx = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
        dy = 0;
        if ($urandom_range(0, 1) != 0) begin
          dy = dx;
          dx = 0;
        end
      end else begin
        // arbitrary vector, every bit free
        dx = $signed(16'($urandom));
        dy = $signed(16'($urandom));
      end
      kind = $urandom_range(0, 9);
      if (kind < 6)      len = $urandom_range(16, 4000);
      else if (kind < 8) len = $urandom_range(0, 15);
      else               len = $urandom_range(0, 32767);
      thick = $urandom_range(0, 63);
      flow  = FLOW_W'($urandom_range(0, 3));
      program_arrow(ox, oy, dx, dy, len, thick, flow);

      ux = cur_dx / 16384.0;
      uy = cur_dy / 16384.0;
      span = (cur_len < ONE_PX ? ONE_PX : cur_len) / ONE_PX;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          if ($urandom_range(0, 9) < 7) begin
            // aim along the axis and across it, a little past both ends
            tp = int'($urandom_range(0, span + 6)) - 3;
            sp = int'($urandom_range(0, 80)) - 40;
            xi = $rtoi(cur_ox + tp * ux - sp * uy);
            yi = $rtoi(cur_oy + tp * uy + sp * ux);
          end else begin
            xi = $urandom_range(0, 1023);
            yi = $urandom_range(0, 1023);
          end
          classify_at(xi, yi);
          counted++;
        end else if (pick < 90) begin
          tick_by($urandom_range(0, 4095));
          counted++;
        end else if (pick < 96) begin
          send_request(OP_RESTART, COORD_BITS'($urandom), COORD_BITS'($urandom),
                       STEP_W'($urandom));
          counted++;
        end else begin
          send_request(OP_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
                       STEP_W'($urandom));
        end
      end
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
